/* rtl/oal_pkg.sv */
// ----------------------------------------------------------------------------
// oal_pkg
// Shared codes and field widths for the ordered array list.
// ----------------------------------------------------------------------------
package oal_pkg;

	// Operation codes carried in the request's tuser.
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_GET    = 2'd2;
	localparam logic [1:0] OP_FIND   = 2'd3;

	// Field widths fixed by the interface.
	localparam int MODE_W  = 2;
	localparam int POS_W   = 7;
	localparam int VALUE_W = 32;
	localparam int TOTAL_W = 7;

	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [POS_W-1:0]   pos_t;

endpackage

/* rtl/ordered_array_list.sv */
// ----------------------------------------------------------------------------
// ordered_array_list
// Fixed-capacity ordered list of signed 32-bit values with 1-based positions.
// ----------------------------------------------------------------------------
// A request makes R reads of the store, one a cycle, then its result is
// registered. R is count-pos+1 for insert, count-pos for delete, 1 for get,
// up to the first match for find, 0 if rejected. Completion waits while the
// previous result is still held by the receiver, and the next item can be
// accepted in the same cycle as the result appears.
// Reset clears the entry count and the handshake state, not the store.
module ordered_array_list
	import oal_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request channel.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [6:0] position, [38:7] value, [39] zero fill
	input  logic [1:0]  s_tuser,  // [1:0] mode
	// Result channel.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // [0] ok, [32:1] read_value,
	                              // [39:33] found_position, [46:40] entry_total,
	                              // [47] zero fill
);

	// Address width of the store and width of the entry count.
	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	// Width wide enough to compare a position against the count without loss.
	localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

	// Sequencer states.
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	logic          state_q;
	logic [1:0]    op_q;
	value_t        val_q;
	logic [AW-1:0] slot_q;
	logic          legal_q;
	logic [CW-1:0] rem_q;
	logic [AW-1:0] ptr_q;
	logic          pend_s1;
	logic [AW-1:0] paddr_s1;
	logic          hit_q;
	pos_t          hit_pos_q;
	value_t        rdv_q;
	logic [CW-1:0] count_q;
	logic          m_tvalid_q;
	logic [47:0]   m_tdata_q;

	logic            accept;
	logic [CMPW-1:0] pos_w;
	logic [CMPW-1:0] cnt_w;
	logic            ins_ok;
	logic            acc_ok;
	logic            legal_d;
	logic [CW-1:0]   rem_d;
	logic [AW-1:0]   ptr_d;
	logic            out_free;
	logic            match;
	logic            issue;
	logic            finish;
	logic [CW-1:0]   count_nxt;
	logic            ok_nxt;
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	value_t          ram_wdata;
	value_t          ram_rdata;

	// The store: every shift, read and search goes through this one RAM.
	oal_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (issue),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign pos_w  = CMPW'(s_tdata[6:0]);
	assign cnt_w  = CMPW'(count_q);
	// Insert may go anywhere from the head to one past the tail, if room is left.
	assign ins_ok = (pos_w != '0) && (pos_w <= cnt_w + CMPW'(1))
		&& (cnt_w < CMPW'(CAPACITY));
	// Delete and get need an existing entry.
	assign acc_ok = (pos_w != '0) && (pos_w <= cnt_w);

	// Number of reads and the first read address for the accepted request.
	// Insert walks down from the tail moving each entry up one slot; delete
	// walks up from the entry after the hole moving each one down.
	always_comb begin
		legal_d = 1'b0;
		rem_d   = '0;
		ptr_d   = '0;
		case (s_tuser)
			OP_INSERT: begin
				legal_d = ins_ok;
				if (ins_ok) begin
					rem_d = CW'(cnt_w - pos_w + CMPW'(1));
					ptr_d = AW'(cnt_w - CMPW'(1));
				end
			end
			OP_DELETE: begin
				legal_d = acc_ok;
				if (acc_ok) begin
					rem_d = CW'(cnt_w - pos_w);
					ptr_d = AW'(pos_w);
				end
			end
			OP_GET: begin
				legal_d = acc_ok;
				if (acc_ok) begin
					rem_d = CW'(1);
					ptr_d = AW'(pos_w - CMPW'(1));
				end
			end
			default: begin
				legal_d = 1'b1;
				rem_d   = count_q;
				ptr_d   = '0;
			end
		endcase
	end

	// A find stops at the first matching read and issues nothing more.
	assign match  = pend_s1 && (op_q == OP_FIND) && (ram_rdata == val_q);
	assign issue  = (state_q == ST_WALK) && (rem_q != '0) && !match;
	assign finish = (state_q == ST_WALK) && (rem_q == '0) && !pend_s1 && out_free;

	// Shift writes land one slot away from the read that fed them, so they
	// never hit the address being read in the same cycle. The new value for an
	// insert is written once the shift has drained, when the port is free.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = val_q;
		if (pend_s1) begin
			ram_wdata = ram_rdata;
			if (op_q == OP_INSERT) begin
				ram_we    = 1'b1;
				ram_waddr = paddr_s1 + AW'(1);
			end else if (op_q == OP_DELETE) begin
				ram_we    = 1'b1;
				ram_waddr = paddr_s1 - AW'(1);
			end
		end else if (finish && (op_q == OP_INSERT) && legal_q) begin
			ram_we = 1'b1;
		end
	end

	always_comb begin
		count_nxt = count_q;
		if (legal_q && (op_q == OP_INSERT)) begin
			count_nxt = count_q + CW'(1);
		end else if (legal_q && (op_q == OP_DELETE)) begin
			count_nxt = count_q - CW'(1);
		end
	end

	assign ok_nxt = (op_q == OP_FIND) ? hit_q : legal_q;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			legal_q    <= 1'b0;
			rem_q      <= '0;
			pend_s1    <= 1'b0;
			hit_q      <= 1'b0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= ST_WALK;
				legal_q <= legal_d;
				rem_q   <= rem_d;
				hit_q   <= 1'b0;
			end else if (state_q == ST_WALK) begin
				if (match) begin
					hit_q <= 1'b1;
					rem_q <= '0;
				end else if (issue) begin
					rem_q <= rem_q - CW'(1);
				end
				if (finish) begin
					state_q <= ST_IDLE;
					count_q <= count_nxt;
				end
			end
			pend_s1 <= issue;
			if (finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Request payload, read pointer and result data.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= s_tuser;
			val_q     <= s_tdata[38:7];
			slot_q    <= AW'(pos_w - CMPW'(1));
			ptr_q     <= ptr_d;
			rdv_q     <= '0;
			hit_pos_q <= '0;
		end else begin
			if (issue) begin
				ptr_q <= (op_q == OP_INSERT) ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));
			end
			if (pend_s1 && (op_q == OP_GET)) begin
				rdv_q <= ram_rdata;
			end
			if (match) begin
				hit_pos_q <= POS_W'(paddr_s1) + POS_W'(1);
			end
		end
		if (issue) begin
			paddr_s1 <= ptr_q;
		end
		if (finish) begin
			m_tdata_q <= {1'b0, TOTAL_W'(count_nxt), hit_pos_q, rdv_q, ok_nxt};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// The count never passes the capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(count_q) <= CMPW'(CAPACITY))
		else $error("entry count above capacity");

	// A read is only in flight while a request is being walked.
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == ST_WALK))
		else $error("read in flight outside of a walk");

	// The count changes only when a request completes.
	assert property (@(posedge clk) disable iff (!arst_n)
		!finish |=> $stable(count_q))
		else $error("entry count changed without a completion");

	// A result appears only right after a walk has completed.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(finish))
		else $error("result raised without a completion");

endmodule

/* rtl/oal_ram.sv */
// ----------------------------------------------------------------------------
// oal_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module oal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered array list. A driver sends a short
// directed run and then random requests in waves that fill the list to full
// and drain it to empty. An in-bench model of the list predicts every
// result, and a monitor compares each returned item with the oldest
// prediction. Both handshake sides stall at random in the first two thirds of the run.
// ----------------------------------------------------------------------------
module tb_top;
	import oal_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY    = 64;
	localparam int RANDOM_REQS = 900;

	// One request as the driver sends it. When hold_until_idle is set, the
	// driver keeps this item back until every earlier result has come back.
	typedef struct {
		logic [MODE_W-1:0] mode;
		pos_t              position;
		value_t            value;
		bit                hold_until_idle;
	} list_request_t;

	// One result, split into its fields.
	typedef struct {
		logic               ok;
		value_t             read_value;
		pos_t               found_position;
		logic [TOTAL_W-1:0] entry_total;
	} list_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // [6:0] position, [38:7] value, [39] zero fill
	logic [1:0]  s_tuser = '0;   // [1:0] mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;        // [0] ok, [32:1] read_value,
	                             // [39:33] found_position, [46:40] entry_total

	// Requests waiting to be sent and results waiting to be checked.
	list_request_t pending_requests[$];
	list_result_t  predicted_results[$];
	list_request_t request_on_bus;

	// The bench's own copy of the list contents and its length.
	value_t list_entries[CAPACITY];
	int     list_length = 0;

	int accepted_count = 0;
	int total_requests = 0;
	int error_count    = 0;

	// Entry count as the stimulus generator sees it, so that most random
	// positions land inside the list.
	int planned_length = 0;

	ordered_array_list #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #2 clk = ~clk;

	// Applies one request to the bench's list and returns what the block
	// must answer. Positions are 1-based, so entry k sits at index k-1.
	function automatic list_result_t list_apply(list_request_t req);
		list_result_t res;
		int           p;
		res = '{ok: 1'b0, read_value: '0, found_position: '0, entry_total: '0};
		p = req.position;
		case (req.mode)
			OP_INSERT: begin
				if (p >= 1 && p <= list_length + 1 && list_length < CAPACITY) begin
					for (int i = list_length; i > p - 1; i--)
						list_entries[i] = list_entries[i-1];
					list_entries[p-1] = req.value;
					list_length++;
					res.ok = 1'b1;
				end
			end
			OP_DELETE: begin
				if (p >= 1 && p <= list_length) begin
					for (int i = p - 1; i + 1 < list_length; i++)
						list_entries[i] = list_entries[i+1];
					list_length--;
					res.ok = 1'b1;
				end
			end
			OP_GET: begin
				if (p >= 1 && p <= list_length) begin
					res.read_value = list_entries[p-1];
					res.ok = 1'b1;
				end
			end
			default: begin
				// Find stops at the first match, so duplicates report the
				// lowest position.
				for (int i = 0; i < list_length; i++) begin
					if (res.ok == 1'b0 && list_entries[i] == req.value) begin
						res.found_position = pos_t'(i + 1);
						res.ok = 1'b1;
					end
				end
			end
		endcase
		res.entry_total = TOTAL_W'(list_length);
		return res;
	endfunction

	// Queues a request and keeps the generator's view of the count current.
	task automatic queue_request(logic [MODE_W-1:0] mode, int position, value_t value,
		bit hold_until_idle = 1'b0);
		list_request_t req;
		req.mode            = mode;
		req.position        = pos_t'(position);
		req.value           = value;
		req.hold_until_idle = hold_until_idle;
		pending_requests.push_back(req);
		if (mode == OP_INSERT && position >= 1 && position <= planned_length + 1 &&
				planned_length < CAPACITY)
			planned_length++;
		else if (mode == OP_DELETE && position >= 1 && position <= planned_length)
			planned_length--;
	endtask

	// Idle share in percent. The first third of the run has a mostly idle
	// receiver, the second a mostly idle sender, and the last third none.
	function automatic int idle_percent(bit receiver);
		int third;
		third = (total_requests == 0) ? 0 : accepted_count * 3 / total_requests;
		if (third == 0)
			return receiver ? 74 : 27;
		else if (third == 1)
			return receiver ? 27 : 74;
		return 0;
	endfunction

	task automatic check_field(string name, logic [31:0] expected_val, logic [31:0] actual_val);
		if (expected_val !== actual_val) begin
			$display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
				$time, name, expected_val, actual_val);
			error_count++;
		end
	endtask

	// Driver. The accepted item is run through the model at the edge that
	// accepts it; the next item is then offered unless the sender idles or must wait.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				predicted_results.push_back(list_apply(request_on_bus));
				accepted_count++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_requests.size() != 0 &&
						!(pending_requests[0].hold_until_idle && predicted_results.size() != 0) &&
						$urandom_range(99) >= idle_percent(1'b0)) begin
					request_on_bus = pending_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {1'b0, request_on_bus.value, request_on_bus.position};
					s_tuser  <= request_on_bus.mode;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// The receiver's ready toggles at random, with its own idle share.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= idle_percent(1'b1));
		end
	end

	// Monitor. Every accepted result is matched against the oldest prediction.
	always @(posedge clk) begin
		list_result_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			if (predicted_results.size() == 0) begin
				$display("%0t: result with no request waiting, expected none, actual 0x%012h",
					$time, m_tdata);
				error_count++;
			end else begin
				exp_res = predicted_results.pop_front();
				check_field("ok", 32'(exp_res.ok), 32'(m_tdata[0]));
				check_field("read_value", exp_res.read_value, m_tdata[32:1]);
				check_field("found_position", 32'(exp_res.found_position), 32'(m_tdata[39:33]));
				check_field("entry_total", 32'(exp_res.entry_total), 32'(m_tdata[46:40]));
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		value_t common_values[6];
		logic [MODE_W-1:0] mode;
		int     roll;
		int     position;
		value_t value;
		bit     growing;

		// A handful of recurring values gives duplicates, so finds hit often
		// and sometimes see more than one match.
		common_values = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h5A5A_A5A5};

		// Directed part: requests against an empty list, inserts at the front,
		// the middle and the end, the value extremes, bad positions for every
		// mode, finds with several matches and with none.
		queue_request(OP_GET,    1,   '0);
		queue_request(OP_DELETE, 1,   '0);
		queue_request(OP_FIND,   0,   32'h0000_0000);
		queue_request(OP_INSERT, 0,   32'h1234_5678);
		queue_request(OP_INSERT, 2,   32'h1234_5678);
		queue_request(OP_INSERT, 1,   32'h7FFF_FFFF);
		queue_request(OP_INSERT, 1,   32'h8000_0000);
		queue_request(OP_INSERT, 3,   32'hFFFF_FFFF);
		queue_request(OP_INSERT, 2,   32'h0000_0000);
		queue_request(OP_INSERT, 127, 32'hFFFF_FFFF);
		queue_request(OP_GET,    4,   32'hFFFF_FFFF);
		queue_request(OP_GET,    0,   '0);
		queue_request(OP_GET,    5,   '0);
		queue_request(OP_GET,    127, '0);
		queue_request(OP_FIND,   127, 32'h8000_0000);
		queue_request(OP_INSERT, 1,   32'hFFFF_FFFF);
		queue_request(OP_FIND,   0,   32'hFFFF_FFFF);
		queue_request(OP_FIND,   0,   32'h0BAD_CAFE);
		queue_request(OP_DELETE, 5,   '0);
		queue_request(OP_DELETE, 1,   '0);
		queue_request(OP_DELETE, 0,   '0);
		queue_request(OP_DELETE, 127, '0);
		queue_request(OP_GET,    1,   '0);

		// Random part in waves: a growing wave mostly inserts until the list
		// is full and keeps trying a few inserts there, then a shrinking wave
		// mostly deletes down to empty. A few positions are drawn from the
		// full field range to hit the rejects.
		growing = 1'b1;
		for (int n = 0; n < RANDOM_REQS; n++) begin
			roll = $urandom_range(99);
			if (growing)
				mode = (roll < 60) ? OP_INSERT : (roll < 75) ? OP_DELETE :
					(roll < 88) ? OP_GET : OP_FIND;
			else
				mode = (roll < 15) ? OP_INSERT : (roll < 65) ? OP_DELETE :
					(roll < 82) ? OP_GET : OP_FIND;
			if ($urandom_range(99) < 12)
				position = $urandom_range(127);
			else if (mode == OP_INSERT)
				position = $urandom_range(planned_length + 1, 1);
			else
				position = (planned_length == 0) ? 1 : $urandom_range(planned_length, 1);
			value = ($urandom_range(99) < 45) ? common_values[$urandom_range(5)] : $urandom();
			// Halfway through, the sender waits for every result to drain.
			queue_request(mode, position, value, n == RANDOM_REQS / 2);
			if (planned_length == CAPACITY && $urandom_range(9) == 0)
				growing = 1'b0;
			else if (planned_length == 0)
				growing = 1'b1;
		end
		total_requests = pending_requests.size();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Checked between edges, once the driver's updates have settled.
		while (pending_requests.size() != 0 || s_tvalid || predicted_results.size() != 0)
			@(negedge clk);
		// Allow for a stray result arriving after the last expected one.
		repeat (CAPACITY + 8) @(posedge clk);

		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#4_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* files.f */
rtl/oal_pkg.sv
rtl/oal_ram.sv
rtl/ordered_array_list.sv
tb/tb_top.sv
